### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge of clk while rst_n is high
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// check prop at every rising edge of clk
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### sv/fcac_pkg.sv
// ----------------------------------------------------------------------------
// fcac_pkg: frame CRC-8 and alive counter checker definitions
// Constants, queue entry type, failure codes and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package fcac_pkg;

  localparam int unsigned CHANNELS_DEF    = 3;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned TOTAL_WIDTH     = 32;

  localparam logic [7:0] CRC_POLY   = 8'h1D;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_XOROUT = 8'hFF;
  localparam logic [7:0] CRC_MSB    = 8'h80;

  typedef enum logic [1:0] {
    FAIL_NONE = 2'd0,
    FAIL_CRC  = 2'd1,
    FAIL_SEQ  = 2'd2
  } fail_e;

  typedef struct packed {
    logic [7:0] crc;
    logic [1:0] channel;
    logic [3:0] alive;
    logic [7:0] check;
  } frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### sv/frame_crc8_alive_checker_core.sv
// ----------------------------------------------------------------------------
// frame_crc8_alive_checker_core: end-to-end frame checker
// CRC-8 (poly 0x1D, init 0xFF, xorout 0xFF) plus 4-bit alive sequence check.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | channel, data_byte, last_byte,
//           |           |                     | alive_count, check_byte
//   out     | output    | out_valid_o/out_stall_i | frame_ok, fail_reason,
//           |           |                     | computed_crc, valid/invalid_total
//
// One byte per cycle while the queue is not full; the CRC byte step in the front end sets that rate.
// After its last byte is taken, a frame goes into the queue and then into the result register.
// Output stall backs up into a two-frame queue; input stalls when it is full.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_crc8_alive_checker_core #(
  parameter int unsigned CHANNELS    = fcac_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH = fcac_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [3:0]  alive_count_i,
  input  logic [7:0]  check_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [1:0]  fail_reason_o,
  output logic [7:0]  computed_crc_o,
  output logic [31:0] valid_total_o,
  output logic [31:0] invalid_total_o
);

  fcac_pkg::frame_t push_data, pop_data;
  logic             push, full, pop, empty;

  fcac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .alive_count_i (alive_count_i),
    .check_byte_i  (check_byte_i),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_data_o      (push_data)
  );

  fcac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  fcac_back #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (empty),
    .q_data_i        (pop_data),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_ok_o      (frame_ok_o),
    .fail_reason_o   (fail_reason_o),
    .computed_crc_o  (computed_crc_o),
    .valid_total_o   (valid_total_o),
    .invalid_total_o (invalid_total_o)
  );

endmodule

### sv/fcac_queue.sv
// ----------------------------------------------------------------------------
// fcac_queue: short frame queue
// Holds finished frames between the CRC front end and the judging back end.
// ----------------------------------------------------------------------------
module fcac_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fcac_pkg::frame_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output fcac_pkg::frame_t pop_data_o
);

  localparam int unsigned PtrW = (fcac_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(fcac_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(fcac_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(fcac_pkg::QUEUE_DEPTH - 1);

  fcac_pkg::frame_t slot_q [fcac_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(fcac_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### sv/fcac_front.sv
// ----------------------------------------------------------------------------
// fcac_front: byte intake and CRC-8 accumulation
// Folds one payload byte per request into the CRC and emits a frame on the
// last byte.
// ----------------------------------------------------------------------------
module fcac_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       channel_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [3:0]       alive_count_i,
  input  logic [7:0]       check_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output fcac_pkg::frame_t q_data_o
);

  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_next;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign crc_next   = fcac_pkg::crc8_step(crc_q, data_byte_i);
  assign q_push_o   = accept && last_byte_i;

  always_comb begin
    q_data_o.crc     = crc_next ^ fcac_pkg::CRC_XOROUT;
    q_data_o.channel = channel_i;
    q_data_o.alive   = alive_count_i;
    q_data_o.check   = check_byte_i;
  end

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = last_byte_i ? fcac_pkg::CRC_INIT : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= fcac_pkg::CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

### sv/fcac_back.sv
// ----------------------------------------------------------------------------
// fcac_back: frame judging and result register
// Checks CRC and alive sequence per channel, keeps totals, holds the result.
// ----------------------------------------------------------------------------
module fcac_back #(
  parameter int unsigned CHANNELS    = fcac_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH = fcac_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  fcac_pkg::frame_t               q_data_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           frame_ok_o,
  output logic [1:0]                     fail_reason_o,
  output logic [7:0]                     computed_crc_o,
  output logic [fcac_pkg::TOTAL_WIDTH-1:0] valid_total_o,
  output logic [fcac_pkg::TOTAL_WIDTH-1:0] invalid_total_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TotW = fcac_pkg::TOTAL_WIDTH;

  logic [3:0]             exp_alive_q [CHANNELS];
  logic [CHANNELS-1:0]    pending_q;
  logic [COUNT_WIDTH-1:0] valid_cnt_q, invalid_cnt_q;
  logic                   out_valid_q;
  logic                   frame_ok_q;
  fcac_pkg::fail_e        reason_q, reason;
  logic [7:0]             crc_q;

  logic [4:0]      ch_ext;
  logic [IdxW-1:0] idx;
  logic            ch_ok, crc_ok, seq_ok;
  logic [3:0]      exp_alive;

  assign ch_ext    = {3'b000, q_data_i.channel};
  assign ch_ok     = (ch_ext < 5'(CHANNELS));
  assign idx       = ch_ext[IdxW-1:0];
  assign crc_ok    = (q_data_i.crc == q_data_i.check);
  assign exp_alive = exp_alive_q[idx];
  assign seq_ok    = pending_q[idx] || (q_data_i.alive == exp_alive) ||
                     (q_data_i.alive == exp_alive + 4'd1);
  assign q_pop_o   = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    priority if (!crc_ok) begin
      reason = fcac_pkg::FAIL_CRC;
    end else if (!ch_ok || !seq_ok) begin
      reason = fcac_pkg::FAIL_SEQ;
    end else begin
      reason = fcac_pkg::FAIL_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      crc_q    <= q_data_i.crc;
      reason_q <= reason;
    end
    if (q_pop_o && crc_ok && ch_ok) begin
      exp_alive_q[idx] <= q_data_i.alive + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      frame_ok_q    <= 1'b0;
      pending_q     <= '1;
      valid_cnt_q   <= '0;
      invalid_cnt_q <= '0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        frame_ok_q  <= (reason == fcac_pkg::FAIL_NONE);
        if (reason == fcac_pkg::FAIL_NONE) begin
          valid_cnt_q <= valid_cnt_q + COUNT_WIDTH'(1);
        end else begin
          invalid_cnt_q <= invalid_cnt_q + COUNT_WIDTH'(1);
        end
        if (crc_ok && ch_ok) begin
          pending_q[idx] <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ok_o     = frame_ok_q;
  assign fail_reason_o  = reason_q;
  assign computed_crc_o = crc_q;

  if (COUNT_WIDTH >= TotW) begin : g_wide_tot
    assign valid_total_o   = valid_cnt_q[TotW-1:0];
    assign invalid_total_o = invalid_cnt_q[TotW-1:0];
  end else begin : g_narrow_tot
    assign valid_total_o   = {(TotW-COUNT_WIDTH)'(0), valid_cnt_q};
    assign invalid_total_o = {(TotW-COUNT_WIDTH)'(0), invalid_cnt_q};
  end

endmodule

### sv/fcac_checker.sv
// ----------------------------------------------------------------------------
// fcac_checker: port-level checks for the frame checker
// Watches the result channel and its consistency over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        frame_ok_o,
  input logic [1:0]  fail_reason_o,
  input logic [7:0]  computed_crc_o
);

  logic held;
  logic ok_expect;

  assign held      = out_valid_o && out_stall_i;
  assign ok_expect = (fail_reason_o == fcac_pkg::FAIL_NONE);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, held |=> out_valid_o && $stable(computed_crc_o))
  `ASSERT_RST(a_ok_matches_reason, clk_i, rst_ni, out_valid_o |-> frame_ok_o == ok_expect)
  `ASSERT_RST(a_reason_legal, clk_i, rst_ni, out_valid_o |-> fail_reason_o <= fcac_pkg::FAIL_SEQ)

endmodule

bind frame_crc8_alive_checker_core fcac_checker u_fcac_checker (.*);
